@@ design/utf8d_pkg.sv @@
package utf8d_pkg;

  localparam int unsigned MaxSeqBytes = 4;
  localparam int unsigned ContShift   = 6;

  localparam logic [20:0] Bound1 = 21'h000080;
  localparam logic [20:0] Bound2 = 21'h000800;
  localparam logic [20:0] Bound3 = 21'h010000;
  localparam logic [20:0] Bound4 = 21'h110000;
  localparam logic [20:0] SurrLo = 21'h00D800;
  localparam logic [20:0] SurrHi = 21'h00DFFF;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_STRAY    = 3'd1,
    ERR_BAD_CONT = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_SURR     = 3'd4,
    ERR_TOO_LONG = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_end;
    err_e        error_code;
  } out_t;

  typedef struct packed {
    logic [2:0]  seen;
    logic [3:0]  wanted;
    logic [20:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } step_res_t;

endpackage

@@ design/utf8d_stream_if.sv @@
interface utf8d_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/utf8_validating_decoder.sv @@
// Streaming UTF-8 decoder that takes one byte word per clock and returns one result word
// for each completed sequence, each error and each end marker, with no result for a byte
// in the middle of a sequence; a word is accepted every cycle unless a stalled output
// holds it back. Each byte is registered in the input register, the sequence-state
// update runs between the input register and the output register, and the result is
// registered in the output register. There is no start-up delay after reset, and a
// stalled output holds its result while one more byte waits in the input register.
module utf8_validating_decoder
  import utf8d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  utf8d_stream_if.sink          in_i,
  utf8d_stream_if.source        out_o
);

  in_t        s1_q;
  logic       s1_vld_q;
  logic       s1_vld_d;
  dec_state_t st_q;
  dec_state_t st_d;
  out_t       res_q;
  logic       res_vld_q;
  logic       res_vld_d;
  step_res_t  step_res;
  logic       advance;
  logic       in_take;

  assign advance     = s1_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  utf8d_step u_step (
    .state_i (st_q),
    .item_i  (s1_q),
    .state_o (st_d),
    .res_o   (step_res)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_take) begin
      s1_vld_d = 1'b1;
    end else if (advance) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = step_res.valid;
    end else if (out_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      res_vld_q <= res_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_i.data;
    end
    if (advance && step_res.valid) begin
      res_q <= step_res.data;
    end
  end

endmodule

@@ design/utf8d_step.sv @@
module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t state_i,
  input  in_t        item_i,
  output dec_state_t state_o,
  output step_res_t  res_o
);

  logic [3:0]  lead_n;
  logic        stop;
  dec_state_t  cand;
  logic        check;
  logic [20:0] lo;
  logic [20:0] hi;
  logic [7:0]  lead_mask;

  always_comb begin
    lead_n = '0;
    stop   = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!stop && item_i.data_byte[i]) begin
        lead_n = lead_n + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign lead_mask = 8'h7F >> lead_n;

  always_comb begin
    state_o                = state_i;
    res_o                  = '0;
    res_o.data.error_code  = ERR_NONE;
    cand                   = state_i;
    check                  = 1'b0;
    lo                     = '0;
    hi                     = Bound1;
    if (item_i.end_of_input) begin
      state_o               = '0;
      res_o.valid           = 1'b1;
      res_o.data.is_end     = 1'b1;
      res_o.data.error_code = (state_i.seen != 3'd0) ? ERR_TRUNC : ERR_NONE;
    end else if (state_i.seen == 3'd0) begin
      if (lead_n == 4'd1) begin
        state_o               = '0;
        res_o.valid           = 1'b1;
        res_o.data.error_code = ERR_STRAY;
      end else begin
        cand.wanted  = (lead_n == 4'd0) ? 4'd1 : lead_n;
        cand.partial = (lead_n == 4'd0) ? {13'd0, item_i.data_byte}
                                        : {13'd0, item_i.data_byte & lead_mask};
        cand.seen    = 3'd1;
        check        = 1'b1;
      end
    end else if (state_i.seen >= 3'(MaxSeqBytes)) begin
      state_o               = '0;
      res_o.valid           = 1'b1;
      res_o.data.error_code = ERR_TOO_LONG;
    end else if (item_i.data_byte[7:6] != 2'b10) begin
      state_o               = '0;
      res_o.valid           = 1'b1;
      res_o.data.error_code = ERR_BAD_CONT;
    end else begin
      cand.partial = {state_i.partial[20-ContShift:0], item_i.data_byte[ContShift-1:0]};
      cand.seen    = state_i.seen + 3'd1;
      check        = 1'b1;
    end

    case (cand.seen)
      3'd2: begin
        lo = Bound1;
        hi = Bound2;
      end
      3'd3: begin
        lo = Bound2;
        hi = Bound3;
      end
      3'd4: begin
        lo = Bound3;
        hi = Bound4;
      end
      default: begin
        lo = '0;
        hi = Bound1;
      end
    endcase

    if (check) begin
      if ({1'b0, cand.seen} == cand.wanted) begin
        state_o     = '0;
        res_o.valid = 1'b1;
        if (cand.partial < lo || cand.partial >= hi) begin
          res_o.data.error_code = ERR_RANGE;
        end else if (cand.partial >= SurrLo && cand.partial <= SurrHi) begin
          res_o.data.error_code = ERR_SURR;
        end else begin
          res_o.data.code_point = cand.partial;
        end
      end else begin
        state_o = cand;
      end
    end
  end

endmodule

@@ design/utf8d_checker.sv @@
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  // A result the sink has not yet taken must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Errors and end markers never carry a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.is_end || out_data_i.error_code != ERR_NONE)
    |-> out_data_i.code_point == 21'd0)
    else $error("code point on error or end marker");

  // The truncation error is reported on the end marker and on nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.is_end
                     == (out_data_i.error_code == ERR_TRUNC
                         || (out_data_i.is_end && out_data_i.error_code == ERR_NONE))))
    else $error("end marker and error code disagree");

  // A good result is a Unicode scalar value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.error_code == ERR_NONE |->
      out_data_i.code_point < Bound4
      && (out_data_i.code_point < SurrLo || out_data_i.code_point > SurrHi))
    else $error("decoded value is not a scalar value");

endmodule

bind utf8_validating_decoder utf8d_checker u_utf8d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ sim/utf8_validating_decoder_test.sv @@
`timescale 1ns / 1ps

module utf8_validating_decoder_test;
  import utf8d_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned RandomWords  = 600;

  localparam logic [8*25-1:0] DirectedBytes = {
    8'h00, 8'h7F, 8'h80, 8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F,
    8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hC2, 8'h41, 8'hFF, 8'hBF,
    8'h80, 8'h80, 8'h00, 8'hE2, 8'h82
  };

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  utf8d_stream_if #(.T(in_t))  in_if ();
  utf8d_stream_if #(.T(out_t)) out_if ();

  utf8_validating_decoder u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [2:0]  dec_seen;
  logic [3:0]  dec_wanted;
  logic [20:0] dec_acc;

  out_t        expected_decodes[$];
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned end_count    = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned kind_count[8];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_decoder();
    dec_seen   = '0;
    dec_wanted = '0;
    dec_acc    = '0;
  endfunction

  function automatic bit decode_word(input in_t w, output out_t res);
    int unsigned ones;
    logic [20:0] value;
    logic [20:0] floor_val;
    logic [20:0] ceil_val;
    logic [2:0]  len;
    res.code_point = '0;
    res.is_end     = 1'b0;
    res.error_code = ERR_NONE;
    if (w.end_of_input) begin
      res.is_end     = 1'b1;
      res.error_code = (dec_seen != 0) ? ERR_TRUNC : ERR_NONE;
      clear_decoder();
      return 1'b1;
    end
    if (dec_seen == 0) begin
      ones = 0;
      while (ones < 8 && w.data_byte[7 - ones]) ones++;
      if (ones == 1) begin
        res.error_code = ERR_STRAY;
        return 1'b1;
      end
      dec_wanted = (ones == 0) ? 4'd1 : 4'(ones);
      dec_acc    = (ones == 0) ? {13'd0, w.data_byte} : {13'd0, w.data_byte & (8'h7F >> ones)};
      dec_seen   = 3'd1;
    end else begin
      if (dec_seen >= MaxSeqBytes) begin
        clear_decoder();
        res.error_code = ERR_TOO_LONG;
        return 1'b1;
      end
      if (w.data_byte[7:6] != 2'b10) begin
        clear_decoder();
        res.error_code = ERR_BAD_CONT;
        return 1'b1;
      end
      dec_acc  = {dec_acc[14:0], w.data_byte[5:0]};
      dec_seen = dec_seen + 3'd1;
    end
    if ({1'b0, dec_seen} != dec_wanted) return 1'b0;
    value = dec_acc;
    len   = dec_seen;
    clear_decoder();
    case (len)
      3'd1: begin
        floor_val = '0;
        ceil_val  = Bound1;
      end
      3'd2: begin
        floor_val = Bound1;
        ceil_val  = Bound2;
      end
      3'd3: begin
        floor_val = Bound2;
        ceil_val  = Bound3;
      end
      default: begin
        floor_val = Bound3;
        ceil_val  = Bound4;
      end
    endcase
    if (value < floor_val || value >= ceil_val) res.error_code = ERR_RANGE;
    else if (value >= SurrLo && value <= SurrHi) res.error_code = ERR_SURR;
    else res.code_point = value;
    return 1'b1;
  endfunction

  function automatic byte_q_t encode_point(input logic [20:0] cp, input int unsigned len);
    byte_q_t seq;
    case (len)
      1: begin
        seq.push_back({1'b0, cp[6:0]});
      end
      2: begin
        seq.push_back({3'b110, cp[10:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq.push_back({4'b1110, cp[15:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq.push_back({5'b11110, cp[20:18]});
        seq.push_back({2'b10, cp[17:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
    endcase
    return seq;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("mismatch at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_decodes.size() == 0) begin
      report_mismatch("unexpected result word, code point", 32'(got.code_point), 32'd0);
    end else begin
      want = expected_decodes.pop_front();
      if (got.code_point !== want.code_point) begin
        report_mismatch("code point", 32'(got.code_point), 32'(want.code_point));
      end
      if (got.is_end !== want.is_end) begin
        report_mismatch("end flag", 32'(got.is_end), 32'(want.is_end));
      end
      if (got.error_code !== want.error_code) begin
        report_mismatch("error code", 32'(got.error_code), 32'(want.error_code));
      end
      results_seen++;
      if (want.is_end) end_count++;
      kind_count[want.error_code]++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result(out_if.data);
  end

  task automatic send_word(input logic [7:0] data_byte, input logic eoi);
    in_t  w;
    out_t res;
    w.data_byte    = data_byte;
    w.end_of_input = eoi;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    words_sent++;
    if (decode_word(w, res)) expected_decodes.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 16);
    end
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_random_sequence();
    byte_q_t     seq;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    len  = 0;
    cp   = '0;
    if (pick < 20) begin
      len = 1;
      cp  = 21'($urandom_range(0, 'h7F));
    end else if (pick < 35) begin
      len = 2;
      cp  = 21'($urandom_range('h80, 'h7FF));
    end else if (pick < 50) begin
      len = 3;
      cp  = 21'($urandom_range('h800, 'hFFFF));
    end else if (pick < 62) begin
      len = 4;
      cp  = 21'($urandom_range('h10000, 'h10FFFF));
    end else if (pick < 66) begin
      len = 3;
      cp  = 21'($urandom_range('hD800, 'hDFFF));
    end else if (pick < 72) begin
      len = $urandom_range(2, 4);
      cp  = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
    end else if (pick < 76) begin
      len = 4;
      cp  = 21'($urandom_range('h110000, 'h1FFFFF));
    end else if (pick < 86) begin
      repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
    end else if (pick < 93) begin
      seq.push_back(8'($urandom_range('hF8, 'hFF)));
      repeat ($urandom_range(3, 6)) seq.push_back({2'b10, 6'($urandom)});
    end
    if (len != 0) seq = encode_point(cp, len);
    if (seq.size() > 1 && $urandom_range(0, 11) == 0) begin
      seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom);
    end
    if (seq.size() == 0) begin
      send_word(8'($urandom), 1'b1);
    end else if (len > 1 && $urandom_range(0, 24) == 0) begin
      cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++) send_word(seq[i], 1'b0);
      send_word(8'($urandom), 1'b1);
    end else begin
      foreach (seq[i]) send_word(seq[i], 1'b0);
    end
  endtask

  task automatic test_directed();
    for (int i = 24; i >= 0; i--) send_word(DirectedBytes[i*8 +: 8], 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_random_stream();
    while (words_sent < RandomWords) send_random_sequence();
  endtask

  task automatic test_backpressure();
    int unsigned target;
    target     = words_sent + 80;
    burst_left = 200;
    hold_left  = HoldCycles;
    while (words_sent < target) send_random_sequence();
  endtask

  task automatic test_drain_pause();
    int unsigned target;
    repeat (3) begin
      target = words_sent + 30;
      while (words_sent < target) send_random_sequence();
      wait_for_drain();
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned mode;
    phase = 0;
    mode  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= (phase % 5 >= 2);
          end
          2: begin
            out_if.ready <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            out_if.ready <= (phase % 16 >= 10);
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    clear_decoder();
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_stream();
    test_backpressure();
    test_drain_pause();
    wait_for_drain();
    $display("Sent %0d byte words and checked %0d results, %0d of them end markers.",
             words_sent, results_seen, end_count);
    $display("Outcomes: ok %0d, stray %0d, bad continuation %0d, range %0d, surrogate %0d, too long %0d, truncated %0d.",
             kind_count[ERR_NONE], kind_count[ERR_STRAY], kind_count[ERR_BAD_CONT],
             kind_count[ERR_RANGE], kind_count[ERR_SURR], kind_count[ERR_TOO_LONG],
             kind_count[ERR_TRUNC]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
